// ----- hdl/fpns_pkg.sv -----
package fpns_pkg;

  // Operand format.
  localparam int FRACTION_BITS = 16;
  localparam int MAX_STEPS     = 64;

  localparam int VALUE_W = 48;
  localparam int GUESS_W = 48;
  localparam int ROOT_W  = 32;
  localparam int STEPS_W = 7;

  // The dividend is a positive operand shifted left by the fraction bits.
  localparam int DIVIDEND_W = VALUE_W - 1 + FRACTION_BITS;
  // Estimates can grow to the dividend's width after the first step.
  localparam int EST_W      = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [GUESS_W-1:0] start_guess;
  } sqrt_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  root;
    logic [STEPS_W-1:0] steps;
  } sqrt_out_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [EST_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/fpns_div.sv -----
module fpns_div
  import fpns_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  running;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [EST_W-1:0]      rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [EST_W-1:0]      divisor;
  logic                  done;

  logic [EST_W:0]        shifted;
  logic                  fits;
  logic [EST_W:0]        diff;

  // Restoring division: one quotient bit per cycle, most significant first.
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    fits    = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_W'(DIVIDEND_W - 1);
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (running) begin
        if (fits) begin
          rem <= diff[EST_W-1:0];
        end else begin
          rem <= shifted[EST_W-1:0];
        end
        quo <= {quo[DIVIDEND_W-2:0], fits};
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- hdl/fixed_point_newton_sqrt.sv -----
// Fixed-point square root by Newton iteration. A transfer is taken at a
// clock edge with start high and busy low; operand.value is a signed raw
// value with 16 fraction bits and operand.start_guess an optional first
// estimate (0 picks value/2, raised to 1 when that is 0). The result
// (root with 16 fraction bits, and the number of Newton steps) appears on
// the result port for exactly one cycle, marked by done, and must be taken
// then: the receiver cannot stall the block. A value of zero or less gives
// root 0 and steps 0 in the cycle after the transfer. Otherwise every Newton
// step runs one 63-bit by 63-bit division on a shared restoring divider
// that produces one quotient bit per cycle; a step issues the division,
// waits for its end and then checks convergence, for at most 64 steps. For
// a positive value the block holds busy high until the result appears
// and works on one item at a time.
module fixed_point_newton_sqrt
  import fpns_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sqrt_in_t  operand,
  output logic      busy,
  output logic      done,
  output sqrt_out_t result
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0]            state;
  logic [EST_W-1:0]      est;
  logic [EST_W-1:0]      prev;
  logic [DIVIDEND_W-1:0] dividend;
  logic [STEPS_W-1:0]    steps;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic                  accept;
  logic                  nonpositive;
  logic [EST_W-1:0]      half_value;
  logic [EST_W-1:0]      first_est;
  logic [EST_W:0]        sum;
  logic [EST_W-1:0]      delta;
  logic                  keep_going;
  logic [ROOT_W-1:0]     root_sat;

  assign accept      = start && !busy;
  assign busy        = state != S_IDLE;
  assign nonpositive = operand.value[VALUE_W-1] || (operand.value == '0);

  // Default start: half the operand, never below one.
  always_comb begin
    half_value = EST_W'(operand.value[VALUE_W-1:1]);
    if (operand.start_guess != '0) begin
      first_est = EST_W'(operand.start_guess);
    end else if (half_value == '0) begin
      first_est = EST_W'(1);
    end else begin
      first_est = half_value;
    end
  end

  // The divider is started once per step; a zero estimate divides by one.
  always_comb begin
    div_req.start    = state == S_ISSUE;
    div_req.dividend = dividend;
    div_req.divisor  = (est == '0) ? EST_W'(1) : est;
  end

  fpns_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // The sum of the estimate and the quotient is one bit wider than either.
  assign sum = {1'b0, est} + {1'b0, div_rsp.quotient};

  // Convergence: stop once two successive estimates are within one or the step limit is reached; saturate the root.
  always_comb begin
    delta      = (est > prev) ? (est - prev) : (prev - est);
    keep_going = (delta > EST_W'(1)) && (steps < STEPS_W'(MAX_STEPS));
    if (est > EST_W'({ROOT_W{1'b1}})) begin
      root_sat = '1;
    end else begin
      root_sat = est[ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (nonpositive) begin
              done         <= 1'b1;
              result.root  <= '0;
              result.steps <= '0;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (keep_going) begin
            state <= S_ISSUE;
          end else begin
            state        <= S_IDLE;
            done         <= 1'b1;
            result.root  <= root_sat;
            result.steps <= steps;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the iteration.
  always_ff @(posedge clk) begin
    if (accept) begin
      dividend <= {operand.value[VALUE_W-2:0], {FRACTION_BITS{1'b0}}};
      est      <= first_est;
      steps    <= '0;
    end else if (state == S_WAIT && div_rsp.done) begin
      prev  <= est;
      est   <= sum[EST_W:1];
      steps <= steps + 1'b1;
    end
  end

  // A result is never shown while another item is at work.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // A nonpositive operand gives a zero result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (accept && nonpositive) |=> (done && result.root == '0 && result.steps == '0))
    else $error("nonpositive operand not answered at once");

  // The step count never passes the limit.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.steps <= STEPS_W'(MAX_STEPS)))
    else $error("step count beyond limit");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WAIT))
    else $error("divider finished outside a step");

endmodule
